>>> hw/rtl/float_sample_to_pixel_packer_macros.svh
// ----------------------------------------------------------------------------
// float_sample_to_pixel_packer_macros.svh
// assertion macros shared by the packer rtl
// ----------------------------------------------------------------------------
`ifndef FLOAT_SAMPLE_TO_PIXEL_PACKER_MACROS_SVH
`define FLOAT_SAMPLE_TO_PIXEL_PACKER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define FSP_ASSERT_IMPLIES(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("packer assertion failed");

// next-cycle implication
`define FSP_ASSERT_NEXT(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("packer assertion failed");

`else

`define FSP_ASSERT_IMPLIES(lbl, clock, reset, ante, cons)
`define FSP_ASSERT_NEXT(lbl, clock, reset, ante, cons)

`endif

`endif

>>> hw/rtl/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// types and constants shared by the sample-to-pixel packer
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int SAMPLE_W = 20;
  localparam int COMP_W   = 16;
  localparam int COUNT_W  = 3;
  localparam int FMT_W    = 3;
  localparam int CFG_W    = 3;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_RED_BLUE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PRESENT = 2'd2;

  // format code bits
  localparam int FMT_ALPHA_BIT = 0;
  localparam int FMT_COLOR_BIT = 1;
  localparam int FMT_WIDE_BIT  = 2;
  localparam logic [FMT_W-1:0] FMT_RGB8 = 3'd2;

  localparam logic [COMP_W-1:0] MAX8  = 16'd255;
  localparam logic [COMP_W-1:0] MAX16 = 16'd65535;

  localparam logic [COUNT_W-1:0] COUNT_ONE   = 3'd1;
  localparam logic [COUNT_W-1:0] COUNT_TWO   = 3'd2;
  localparam logic [COUNT_W-1:0] COUNT_THREE = 3'd3;
  localparam logic [COUNT_W-1:0] COUNT_FOUR  = 3'd4;

  // configuration as seen by the pipeline
  typedef struct packed {
    logic [FMT_W-1:0] output_format;
    logic             swap_red_blue;
    logic             alpha_present;
  } cfg_t;

endpackage

>>> hw/rtl/fsp_quant_lane.sv
// ----------------------------------------------------------------------------
// fsp_quant_lane
// quantizes one fixed point sample to 8 or 16 bit unorm, registered output
// ----------------------------------------------------------------------------
module fsp_quant_lane import fsp_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                wide,
  output logic [COMP_W-1:0]   quant
);

  localparam int PROD_W = SAMPLE_W + COMP_W + 1;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRACTION_BITS - 1);

  logic [PROD_W-1:0] mag;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;
  logic [PROD_W-1:0] shifted;
  logic [PROD_W-1:0] maxval_ext;
  logic [COMP_W-1:0] maxval;
  logic              non_positive;
  logic [COMP_W-1:0] quant_next;

  // sample times maxval as shift and subtract
  assign mag     = {{(PROD_W-SAMPLE_W){1'b0}}, sample};
  assign prod    = wide ? ((mag << 16) - mag) : ((mag << 8) - mag);
  assign rounded = prod + HALF;
  assign shifted = rounded >> FRACTION_BITS;

  assign maxval       = wide ? MAX16 : MAX8;
  assign maxval_ext   = {{(PROD_W-COMP_W){1'b0}}, maxval};
  assign non_positive = sample[SAMPLE_W-1] || (sample == '0);

  // clamp at zero and at full scale
  always_comb begin
    if (non_positive) begin
      quant_next = '0;
    end else if (shifted >= maxval_ext) begin
      quant_next = maxval;
    end else begin
      quant_next = shifted[COMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    quant <= quant_next;
  end

endmodule

>>> hw/rtl/fsp_merge.sv
// ----------------------------------------------------------------------------
// fsp_merge
// places the lane results into component order for the selected format
// ----------------------------------------------------------------------------
`include "float_sample_to_pixel_packer_macros.svh"

module fsp_merge import fsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  input  cfg_t               cfg,
  input  logic [COMP_W-1:0]  red_q,
  input  logic [COMP_W-1:0]  green_q,
  input  logic [COMP_W-1:0]  blue_q,
  input  logic [COMP_W-1:0]  alpha_q,
  output logic               done,
  output logic [COMP_W-1:0]  component_0,
  output logic [COMP_W-1:0]  component_1,
  output logic [COMP_W-1:0]  component_2,
  output logic [COMP_W-1:0]  component_3,
  output logic [COUNT_W-1:0] component_count
);

  logic               wide;
  logic               alpha_fmt;
  logic               color;
  logic [COMP_W-1:0]  alpha_val;
  logic [COMP_W-1:0]  c0_next;
  logic [COMP_W-1:0]  c1_next;
  logic [COMP_W-1:0]  c2_next;
  logic [COMP_W-1:0]  c3_next;
  logic [COUNT_W-1:0] count_next;

  assign wide      = cfg.output_format[FMT_WIDE_BIT];
  assign alpha_fmt = cfg.output_format[FMT_ALPHA_BIT];
  assign color     = cfg.output_format[FMT_COLOR_BIT];
  assign alpha_val = cfg.alpha_present ? alpha_q : (wide ? MAX16 : MAX8);

  // component selection
  always_comb begin
    c0_next = '0;
    c1_next = '0;
    c2_next = '0;
    c3_next = '0;
    if (!color) begin
      c0_next    = red_q;
      c1_next    = alpha_fmt ? alpha_val : '0;
      count_next = alpha_fmt ? COUNT_TWO : COUNT_ONE;
    end else begin
      c0_next    = cfg.swap_red_blue ? blue_q : red_q;
      c1_next    = green_q;
      c2_next    = cfg.swap_red_blue ? red_q : blue_q;
      c3_next    = alpha_fmt ? alpha_val : '0;
      count_next = alpha_fmt ? COUNT_FOUR : COUNT_THREE;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    component_0     <= c0_next;
    component_1     <= c1_next;
    component_2     <= c2_next;
    component_3     <= c3_next;
    component_count <= count_next;
  end

  // unused components read as zero
  `FSP_ASSERT_IMPLIES(a_unused_third, clk, rst,
    done && (component_count == COUNT_ONE || component_count == COUNT_TWO),
    component_2 == '0 && component_3 == '0)
  `FSP_ASSERT_IMPLIES(a_unused_fourth, clk, rst,
    done && component_count != COUNT_FOUR, component_3 == '0)

endmodule

>>> hw/rtl/float_sample_to_pixel_packer.sv
// ----------------------------------------------------------------------------
// float_sample_to_pixel_packer
// quantizes rgba fixed point samples to 8/16 bit unorm and packs them
//
//   channel   handshake          payload
//   request   start, busy        red/green/blue/alpha_sample
//   result    done (strobe)      component_0..3, component_count
//   config    cfg_write          cfg_index, cfg_data
//
// one pixel per clock; results pass the lane registers, then the merge register
// stage 1: four quantize lanes (shift-subtract scale, round, clamp)
// stage 2: merge register orders components for the format
// busy stays low; the receiver cannot stall, so nothing backs up
// synchronous reset clears the strobes and loads register defaults
// ----------------------------------------------------------------------------
`include "float_sample_to_pixel_packer_macros.svh"

module float_sample_to_pixel_packer import fsp_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [SAMPLE_W-1:0]  red_sample,
  input  logic [SAMPLE_W-1:0]  green_sample,
  input  logic [SAMPLE_W-1:0]  blue_sample,
  input  logic [SAMPLE_W-1:0]  alpha_sample,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output logic [COMP_W-1:0]    component_0,
  output logic [COMP_W-1:0]    component_1,
  output logic [COMP_W-1:0]    component_2,
  output logic [COMP_W-1:0]    component_3,
  output logic [COUNT_W-1:0]   component_count
);

  cfg_t              cfg;
  cfg_t              cfg_s1;
  logic              accept;
  logic              valid_s1;
  logic              wide;
  logic [COMP_W-1:0] red_q;
  logic [COMP_W-1:0] green_q;
  logic [COMP_W-1:0] blue_q;
  logic [COMP_W-1:0] alpha_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign wide   = cfg.output_format[FMT_WIDE_BIT];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_format <= FMT_RGB8;
      cfg.swap_red_blue <= 1'b0;
      cfg.alpha_present <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OUTPUT_FORMAT: cfg.output_format <= cfg_data;
        REG_SWAP_RED_BLUE: cfg.swap_red_blue <= cfg_data[0];
        REG_ALPHA_PRESENT: cfg.alpha_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
    end else begin
      valid_s1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    cfg_s1 <= cfg;
  end

  // quantize lanes
  fsp_quant_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_red (
    .clk(clk), .sample(red_sample), .wide(wide), .quant(red_q)
  );
  fsp_quant_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_green (
    .clk(clk), .sample(green_sample), .wide(wide), .quant(green_q)
  );
  fsp_quant_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_blue (
    .clk(clk), .sample(blue_sample), .wide(wide), .quant(blue_q)
  );
  fsp_quant_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_alpha (
    .clk(clk), .sample(alpha_sample), .wide(wide), .quant(alpha_q)
  );

  // component ordering
  fsp_merge u_merge (
    .clk(clk),
    .rst(rst),
    .valid(valid_s1),
    .cfg(cfg_s1),
    .red_q(red_q),
    .green_q(green_q),
    .blue_q(blue_q),
    .alpha_q(alpha_q),
    .done(done),
    .component_0(component_0),
    .component_1(component_1),
    .component_2(component_2),
    .component_3(component_3),
    .component_count(component_count)
  );

  // every request gives one result, through valid_s1 and then done
  `FSP_ASSERT_NEXT(a_accept_stage, clk, rst, accept, valid_s1)
  `FSP_ASSERT_NEXT(a_stage_done, clk, rst, valid_s1, done)
  `FSP_ASSERT_IMPLIES(a_done_source, clk, rst, done, $past(valid_s1))
  `FSP_ASSERT_IMPLIES(a_narrow_range, clk, rst,
    done && !$past(cfg_s1.output_format[FMT_WIDE_BIT]),
    component_0[COMP_W-1:8] == '0 && component_1[COMP_W-1:8] == '0)

endmodule

>>> sim/pixel_pack_checker.sv
// ----------------------------------------------------------------------------
// pixel_pack_checker
// watches the request, config and result channels of the sample-to-pixel
// packer, predicts every packed pixel from its own copy of the registers and
// compares each result strobe against the oldest prediction
// ----------------------------------------------------------------------------
module pixel_pack_checker import fsp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [SAMPLE_W-1:0]  red_sample,
  input  logic [SAMPLE_W-1:0]  green_sample,
  input  logic [SAMPLE_W-1:0]  blue_sample,
  input  logic [SAMPLE_W-1:0]  alpha_sample,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 done,
  input  logic [COMP_W-1:0]    component_0,
  input  logic [COMP_W-1:0]    component_1,
  input  logic [COMP_W-1:0]    component_2,
  input  logic [COMP_W-1:0]    component_3,
  input  logic [COUNT_W-1:0]   component_count,
  output int                   fail_count,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COMP_W-1:0]  comp0;
    logic [COMP_W-1:0]  comp1;
    logic [COMP_W-1:0]  comp2;
    logic [COMP_W-1:0]  comp3;
    logic [COUNT_W-1:0] count;
  } pixel_t;

  // shadow copy of the configuration registers
  logic [FMT_W-1:0] fmt_shadow;
  logic             swap_shadow;
  logic             alpha_shadow;

  pixel_t packed_pixel_q[$];

  // signed fixed point to unorm: round half up, clamp at maxval
  function automatic logic [COMP_W-1:0] quantize_unorm(logic [SAMPLE_W-1:0] raw,
                                                       logic [COMP_W-1:0] maxval);
    logic [63:0] scaled;
    if ($signed(raw) <= 0) return '0;
    scaled = {44'd0, raw} * {48'd0, maxval} + (64'd1 << (FRAC_BITS - 1));
    scaled = scaled >> FRAC_BITS;
    if (scaled >= {48'd0, maxval}) return maxval;
    return scaled[COMP_W-1:0];
  endfunction

  // component order and count for the current format
  function automatic pixel_t pack_pixel(logic [SAMPLE_W-1:0] r_in, logic [SAMPLE_W-1:0] g_in,
                                        logic [SAMPLE_W-1:0] b_in, logic [SAMPLE_W-1:0] a_in);
    pixel_t            px;
    logic [COMP_W-1:0] maxval;
    logic [COMP_W-1:0] r_q;
    logic [COMP_W-1:0] g_q;
    logic [COMP_W-1:0] b_q;
    logic [COMP_W-1:0] a_q;
    logic              alpha_fmt;
    px        = '0;
    maxval    = fmt_shadow[FMT_WIDE_BIT] ? MAX16 : MAX8;
    alpha_fmt = fmt_shadow[FMT_ALPHA_BIT];
    r_q = quantize_unorm(r_in, maxval);
    g_q = quantize_unorm(g_in, maxval);
    b_q = quantize_unorm(b_in, maxval);
    a_q = alpha_shadow ? quantize_unorm(a_in, maxval) : maxval;
    if (!fmt_shadow[FMT_COLOR_BIT]) begin
      px.comp0 = r_q;
      if (alpha_fmt) px.comp1 = a_q;
      px.count = alpha_fmt ? COUNT_TWO : COUNT_ONE;
    end else begin
      px.comp0 = swap_shadow ? b_q : r_q;
      px.comp1 = g_q;
      px.comp2 = swap_shadow ? r_q : b_q;
      if (alpha_fmt) px.comp3 = a_q;
      px.count = alpha_fmt ? COUNT_FOUR : COUNT_THREE;
    end
    return px;
  endfunction

  task automatic check_field(string name, logic [COMP_W-1:0] want, logic [COMP_W-1:0] got);
    if (got !== want) begin
      $error("pixel field %s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // compare results, then queue the new request, then track config writes
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      fmt_shadow   = FMT_RGB8;
      swap_shadow  = 1'b0;
      alpha_shadow = 1'b0;
      packed_pixel_q.delete();
    end else begin
      if (done === 1'b1) begin
        if (packed_pixel_q.size() == 0) begin
          $error("pixel result with no request pending: component_0 %0d", component_0);
          fail_count++;
        end else begin
          want = packed_pixel_q.pop_front();
          check_field("component_0", want.comp0, component_0);
          check_field("component_1", want.comp1, component_1);
          check_field("component_2", want.comp2, component_2);
          check_field("component_3", want.comp3, component_3);
          check_field("component_count", COMP_W'(want.count), COMP_W'(component_count));
        end
      end
      if (start && !busy)
        packed_pixel_q.push_back(pack_pixel(red_sample, green_sample, blue_sample,
                                            alpha_sample));
      if (cfg_write) begin
        case (cfg_index)
          REG_OUTPUT_FORMAT: fmt_shadow   = cfg_data[FMT_W-1:0];
          REG_SWAP_RED_BLUE: swap_shadow  = cfg_data[0];
          REG_ALPHA_PRESENT: alpha_shadow = cfg_data[0];
          default: ;
        endcase
      end
    end
    outstanding = packed_pixel_q.size();
  end

endmodule

>>> sim/tb_float_sample_to_pixel_packer.sv
// ----------------------------------------------------------------------------
// tb_float_sample_to_pixel_packer
// drives pixel requests and register writes into the packer: a directed pass
// over sample corners, then random pixels under every format, swap and alpha
// setting with varying sender gaps; the checker scores the results
// ----------------------------------------------------------------------------
module tb_float_sample_to_pixel_packer import fsp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int FRAC_BITS   = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [FMT_W-1:0] FMT_GRAY8        = 3'd0;
  localparam logic [FMT_W-1:0] FMT_GRAY_ALPHA8  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_RGBA8        = 3'd3;
  localparam logic [FMT_W-1:0] FMT_GRAY16       = 3'd4;
  localparam logic [FMT_W-1:0] FMT_GRAY_ALPHA16 = 3'd5;
  localparam logic [FMT_W-1:0] FMT_RGB16        = 3'd6;
  localparam logic [FMT_W-1:0] FMT_RGBA16       = 3'd7;
  localparam logic [FMT_W-1:0] FORMAT_LIST [8] = '{
    FMT_GRAY8, FMT_GRAY_ALPHA8, FMT_RGB8, FMT_RGBA8,
    FMT_GRAY16, FMT_GRAY_ALPHA16, FMT_RGB16, FMT_RGBA16
  };
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // most negative, -1, zero, smallest positive, 8-bit rounding edges,
  // one half, just below one, one, most positive
  localparam int NUM_CORNERS = 12;
  localparam logic [SAMPLE_W-1:0] CORNER_VALS [NUM_CORNERS] = '{
    20'h80000, 20'hFFFFF, 20'h00000, 20'h00001, 20'h00080, 20'h00081,
    20'h08000, 20'h0FF7F, 20'h0FF80, 20'h0FFFF, 20'h10000, 20'h7FFFF
  };
  localparam int IDLE_PCT [3] = '{0, 58, 6};

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [SAMPLE_W-1:0]  red_sample;
  logic [SAMPLE_W-1:0]  green_sample;
  logic [SAMPLE_W-1:0]  blue_sample;
  logic [SAMPLE_W-1:0]  alpha_sample;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 done;
  logic [COMP_W-1:0]    component_0;
  logic [COMP_W-1:0]    component_1;
  logic [COMP_W-1:0]    component_2;
  logic [COMP_W-1:0]    component_3;
  logic [COUNT_W-1:0]   component_count;
  int                   fail_count;
  int                   outstanding;
  int                   cycle_count;

  always #(CLK_PERIOD / 2) clk = ~clk;

  float_sample_to_pixel_packer #(
    .FRACTION_BITS(FRAC_BITS)
  ) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red_sample(red_sample), .green_sample(green_sample),
    .blue_sample(blue_sample), .alpha_sample(alpha_sample),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .component_0(component_0), .component_1(component_1),
    .component_2(component_2), .component_3(component_3),
    .component_count(component_count)
  );

  pixel_pack_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red_sample(red_sample), .green_sample(green_sample),
    .blue_sample(blue_sample), .alpha_sample(alpha_sample),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .component_0(component_0), .component_1(component_1),
    .component_2(component_2), .component_3(component_3),
    .component_count(component_count),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("float_sample_to_pixel_packer verification failed");
      $finish;
    end
  end

  // mix of full-range, in-range, near-one, corner and negative samples
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0, 1:    return SAMPLE_W'($urandom);
      2, 3:    return SAMPLE_W'($urandom_range(0, 32'h10000));
      4:       return SAMPLE_W'($urandom_range(0, 511));
      5:       return SAMPLE_W'($urandom_range(32'hFE00, 32'h10200));
      6:       return CORNER_VALS[$urandom_range(NUM_CORNERS - 1)];
      default: return 20'h80000 | SAMPLE_W'($urandom_range(0, 32'h7FFFF));
    endcase
  endfunction

  // one request, with random sender gaps ahead of it
  task automatic send_pixel(logic [SAMPLE_W-1:0] r_in, logic [SAMPLE_W-1:0] g_in,
                            logic [SAMPLE_W-1:0] b_in, logic [SAMPLE_W-1:0] a_in,
                            int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start        = 1'b0;
      red_sample   = rand_sample();
      green_sample = rand_sample();
      blue_sample  = rand_sample();
      alpha_sample = rand_sample();
    end
    @(negedge clk);
    start        = 1'b1;
    red_sample   = r_in;
    green_sample = g_in;
    blue_sample  = b_in;
    alpha_sample = a_in;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // lower start and let every queued result come out
  task automatic drain_pixels();
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic corner_pass(int idle_pct);
    for (int i = 0; i < NUM_CORNERS; i++)
      send_pixel(CORNER_VALS[i], CORNER_VALS[(i + 3) % NUM_CORNERS],
                 CORNER_VALS[(i + 5) % NUM_CORNERS], CORNER_VALS[(i + 7) % NUM_CORNERS],
                 idle_pct);
  endtask

  initial begin
    int       phase;
    int       n_items;
    logic [1:0] junk;
    rst          = 1'b1;
    start        = 1'b0;
    red_sample   = '0;
    green_sample = '0;
    blue_sample  = '0;
    alpha_sample = '0;
    cfg_write    = 1'b0;
    cfg_index    = REG_OUTPUT_FORMAT;
    cfg_data     = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // corners under the reset configuration
    corner_pass(0);
    drain_pixels();

    // corners at 16-bit rgba with swap and the alpha sample in use
    write_reg(REG_OUTPUT_FORMAT, CFG_W'(FMT_RGBA16));
    write_reg(REG_SWAP_RED_BLUE, 3'b001);
    write_reg(REG_ALPHA_PRESENT, 3'b001);
    write_reg(REG_SPARE, CFG_W'($urandom));
    corner_pass(0);
    drain_pixels();

    // random pixels under every format, swap and alpha setting
    phase = 0;
    for (int f = 0; f < 8; f++) begin
      for (int sw = 0; sw < 2; sw++) begin
        for (int al = 0; al < 2; al++) begin
          write_reg(REG_OUTPUT_FORMAT, CFG_W'(FORMAT_LIST[f]));
          junk = 2'($urandom);
          write_reg(REG_SWAP_RED_BLUE, {junk, sw[0]});
          junk = 2'($urandom);
          write_reg(REG_ALPHA_PRESENT, {junk, al[0]});
          n_items = $urandom_range(16, 30);
          for (int k = 0; k < n_items; k++)
            send_pixel(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                       IDLE_PCT[phase % 3]);
          drain_pixels();
          phase++;
        end
      end
    end

    if (fail_count == 0) begin
      $display("float_sample_to_pixel_packer verification clean");
    end else begin
      $display("float_sample_to_pixel_packer verification failed");
    end
    $finish;
  end

endmodule
